[hw/rtl/efsd_pkg.sv]
`timescale 1ns / 1ps

package efsd_pkg;

    localparam int MAX_SERVERS_DEF = 32;
    localparam int CFG_W           = 6;
    localparam int TIME_W          = 32;
    localparam int SVC_W           = 16;
    localparam int SUM_W           = 48;
    localparam int JOB_W           = 16;
    localparam int IDX_OUT_W       = 5;

    // sequencer steps
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_RD0,
        ST_LOAD,
        ST_CMP,
        ST_CALC,
        ST_COMMIT
    } step_t;

    // branch conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_INPUT,
        C_SCAN_MORE,
        C_SCAN_DONE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  accept;     // input channel ready
        logic  rd_zero;    // read entry 0, scan pointer to 1
        logic  rd_scan;    // read entry at scan pointer, advance
        logic  load_best;  // best <= read data
        logic  cmp_best;   // best <= read data if earlier
        logic  calc;       // start and wait
        logic  commit;     // write back, totals, result
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic scan_more;
        logic out_busy;
    } stat_t;

    // control store
    function automatic ctl_t ucode(input step_t step);
        ctl_t w;
        w = '{accept: 1'b0, rd_zero: 1'b0, rd_scan: 1'b0, load_best: 1'b0,
              cmp_best: 1'b0, calc: 1'b0, commit: 1'b0, cond: C_NONE,
              tgt_true: ST_WAIT, tgt_false: ST_WAIT};
        case (step)
            ST_WAIT: begin
                w.accept    = 1'b1;
                w.cond      = C_NO_INPUT;
                w.tgt_true  = ST_WAIT;
                w.tgt_false = ST_RD0;
            end
            ST_RD0: begin
                w.rd_zero   = 1'b1;
                w.tgt_false = ST_LOAD;
            end
            ST_LOAD: begin
                w.load_best = 1'b1;
                w.rd_scan   = 1'b1;
                w.cond      = C_SCAN_DONE;
                w.tgt_true  = ST_CALC;
                w.tgt_false = ST_CMP;
            end
            ST_CMP: begin
                w.cmp_best  = 1'b1;
                w.rd_scan   = 1'b1;
                w.cond      = C_SCAN_MORE;
                w.tgt_true  = ST_CMP;
                w.tgt_false = ST_CALC;
            end
            ST_CALC: begin
                w.calc      = 1'b1;
                w.tgt_false = ST_COMMIT;
            end
            ST_COMMIT: begin
                w.commit    = 1'b1;
                w.cond      = C_OUT_BUSY;
                w.tgt_true  = ST_COMMIT;
                w.tgt_false = ST_WAIT;
            end
            default: begin
                w.tgt_false = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/efsd_useq.sv]
`timescale 1ns / 1ps

module efsd_useq
    import efsd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output ctl_t  ctl
);

    step_t step_reg, step_next;
    logic  taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        ctl = ucode(step_reg);
        case (ctl.cond)
            C_NONE:      taken = 1'b0;
            C_NO_INPUT:  taken = !stat.in_valid;
            C_SCAN_MORE: taken = stat.scan_more;
            C_SCAN_DONE: taken = !stat.scan_more;
            C_OUT_BUSY:  taken = stat.out_busy;
            default:     taken = 1'b0;
        endcase
        step_next = taken ? ctl.tgt_true : ctl.tgt_false;
    end

endmodule

[hw/rtl/efsd_free_mem.sv]
`timescale 1ns / 1ps

module efsd_free_mem
    import efsd_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [TIME_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [TIME_W-1:0] wr_data
);

    logic [TIME_W-1:0]      mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] valid_reg;
    logic [TIME_W-1:0]      rd_data_reg;

    // entry not yet written in this batch reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/efsd_datapath.sv]
`timescale 1ns / 1ps

module efsd_datapath
    import efsd_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
    localparam int NS_W  = $clog2(MAX_SERVERS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctl_t                 ctl,
    output stat_t                stat,
    input  logic [NS_W-1:0]      n_servers,
    input  logic                 s_valid,
    input  logic [TIME_W-1:0]    s_arrival_time,
    input  logic [SVC_W-1:0]     s_service_time,
    input  logic                 s_batch_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_OUT_W-1:0] m_server_index,
    output logic [TIME_W-1:0]    m_start_time,
    output logic [TIME_W-1:0]    m_wait_time,
    output logic [SUM_W-1:0]     m_total_wait,
    output logic [JOB_W-1:0]     m_jobs_served
);

    logic                 accept;
    logic                 out_busy;
    logic                 fire;
    logic                 scan_more;

    logic [TIME_W-1:0]    arr_reg;
    logic [SVC_W-1:0]     svc_reg;
    logic [NS_W-1:0]      scan_ptr_reg;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic [TIME_W-1:0]    best_val_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_W-1:0]    start_reg;
    logic [TIME_W-1:0]    wait_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [JOB_W-1:0]     cnt_reg, cnt_next;
    logic                 m_valid_reg;
    logic [IDX_OUT_W-1:0] idx_out_reg;
    logic [TIME_W-1:0]    start_out_reg;
    logic [TIME_W-1:0]    wait_out_reg;
    logic [SUM_W-1:0]     sum_out_reg;
    logic [JOB_W-1:0]     cnt_out_reg;

    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [TIME_W-1:0]    mem_rd_data;
    logic [TIME_W-1:0]    finish;
    logic [TIME_W:0]      finish_wide;
    logic [SUM_W:0]       sum_wide;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;

    assign accept    = ctl.accept && s_valid;
    assign out_busy  = m_valid_reg && !m_ready;
    assign fire      = ctl.commit && !out_busy;
    assign scan_more = scan_ptr_reg < n_servers;

    assign stat = '{in_valid: s_valid, scan_more: scan_more, out_busy: out_busy};

    assign mem_rd_en   = ctl.rd_zero || (ctl.rd_scan && scan_more);
    assign mem_rd_addr = ctl.rd_zero ? '0 : scan_ptr_reg[IDX_W-1:0];

    efsd_free_mem #(
        .MAX_SERVERS(MAX_SERVERS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (accept && s_batch_start),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (fire),
        .wr_addr (best_idx_reg),
        .wr_data (finish)
    );

    // saturating arithmetic for write-back and totals
    always_comb begin
        finish_wide = {1'b0, start_reg} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc_reg};
        finish      = finish_wide[TIME_W] ? '1 : finish_wide[TIME_W-1:0];
        sum_wide    = {1'b0, sum_reg} + {{(SUM_W + 1 - TIME_W){1'b0}}, wait_reg};
        sum_next    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        cnt_next    = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        idx_ext     = {{IDX_OUT_W{1'b0}}, best_idx_reg};
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            arr_reg <= s_arrival_time;
            svc_reg <= s_service_time;
        end
        if (ctl.rd_zero) begin
            scan_ptr_reg <= NS_W'(1);
            rd_addr_reg  <= '0;
        end else if (ctl.rd_scan && scan_more) begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
            rd_addr_reg  <= scan_ptr_reg[IDX_W-1:0];
        end
        if (ctl.load_best || (ctl.cmp_best && (mem_rd_data < best_val_reg))) begin
            best_val_reg <= mem_rd_data;
            best_idx_reg <= rd_addr_reg;
        end
        if (ctl.calc) begin
            if (best_val_reg > arr_reg) begin
                start_reg <= best_val_reg;
                wait_reg  <= best_val_reg - arr_reg;
            end else begin
                start_reg <= arr_reg;
                wait_reg  <= '0;
            end
        end
        if (fire) begin
            idx_out_reg   <= idx_ext[IDX_OUT_W-1:0];
            start_out_reg <= start_reg;
            wait_out_reg  <= wait_reg;
            sum_out_reg   <= sum_next;
            cnt_out_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && s_batch_start) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else if (fire) begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_server_index = idx_out_reg;
    assign m_start_time   = start_out_reg;
    assign m_wait_time    = wait_out_reg;
    assign m_total_wait   = sum_out_reg;
    assign m_jobs_served  = cnt_out_reg;

endmodule

[hw/rtl/earliest_free_server_dispatch_unit.sv]
`timescale 1ns / 1ps

// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+------------------------------------------------
// s_       | in  | s_valid / s_ready   | arrival_time, service_time, batch_start
// m_       | out | m_valid / m_ready   | server_index, start_time, wait_time,
//          |     |                     | total_wait, jobs_served
// cfg_     | in  | cfg_valid/cfg_ready | cfg_wdata = server_count
//
// An item's result is registered at write-back, after the scan of the n servers in
// use (1..MAX_SERVERS); a new item is taken only once the sequencer is back in its
// wait step, after write-back of the last one: the microcoded scan reads one free time per cycle
// from the single read port of the free-time store and compares it with the best.
// Reset (aresetn low, synchronous) clears all free times, totals and the step
// counter at once; server_count returns to 1.
// The result sits in an output register, so a stalled m_ready does not hold off
// the next item: the sequencer only waits at write-back if the previous result
// has still not been taken.

module earliest_free_server_dispatch_unit
    import efsd_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_W-1:0]    s_arrival_time,
    input  logic [SVC_W-1:0]     s_service_time,
    input  logic                 s_batch_start,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_OUT_W-1:0] m_server_index,
    output logic [TIME_W-1:0]    m_start_time,
    output logic [TIME_W-1:0]    m_wait_time,
    output logic [SUM_W-1:0]     m_total_wait,
    output logic [JOB_W-1:0]     m_jobs_served
);

    localparam int NS_W = $clog2(MAX_SERVERS + 1);

    logic [CFG_W-1:0] srv_cnt_reg;
    logic [NS_W-1:0]  n_servers;
    ctl_t             ctl;
    stat_t            stat;

    // server_count register; always ready; it is to be written only while idle, which the block itself does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srv_cnt_reg <= CFG_W'(1);
        end else if (cfg_valid) begin
            srv_cnt_reg <= cfg_wdata;
        end
    end

    // zero means one server; anything above the store depth is clipped to it
    always_comb begin
        if (srv_cnt_reg == '0) begin
            n_servers = NS_W'(1);
        end else if (32'(srv_cnt_reg) > 32'(MAX_SERVERS)) begin
            n_servers = NS_W'(MAX_SERVERS);
        end else begin
            n_servers = NS_W'(srv_cnt_reg);
        end
    end

    assign s_ready = ctl.accept;

    // control store and step counter
    efsd_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    // scan, start/wait, write-back, totals and result register
    efsd_datapath #(
        .MAX_SERVERS(MAX_SERVERS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .stat           (stat),
        .n_servers      (n_servers),
        .s_valid        (s_valid),
        .s_arrival_time (s_arrival_time),
        .s_service_time (s_service_time),
        .s_batch_start  (s_batch_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_server_index (m_server_index),
        .m_start_time   (m_start_time),
        .m_wait_time    (m_wait_time),
        .m_total_wait   (m_total_wait),
        .m_jobs_served  (m_jobs_served)
    );

endmodule
